[design/bbm_pkg.sv]
// ----------------------------------------------------------------------------
// Bounding box merge package
// Shared sizes, box and command types for the bounding box merge block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbm_pkg;

  localparam int MaxBoxes   = 64;
  localparam int CoordBits  = 12;
  localparam int IdxBits    = $clog2(MaxBoxes);
  localparam int CntBits    = $clog2(MaxBoxes + 1);
  localparam int BoxBits    = 4 * CoordBits;
  localparam int ExtBits    = CoordBits + 1;
  localparam int CalcBits   = CoordBits + 4;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [CoordBits-1:0] left;
    logic [CoordBits-1:0] top;
    logic [CoordBits-1:0] width;
    logic [CoordBits-1:0] height;
  } bbm_box_t;

  typedef struct packed {
    bbm_box_t box;
    logic     keep;
    logic     last;
  } bbm_cmd_t;

endpackage

`default_nettype wire

[design/bbm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[design/bbm_queue.sv]
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbm_queue
  import bbm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  bbm_cmd_t      cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output bbm_cmd_t      cmd_o,
  output logic          avail_o
);

  localparam int PtrBits = $clog2(QueueDepth);
  localparam int FillBits = $clog2(QueueDepth + 1);

  bbm_cmd_t             slot_q [QueueDepth];
  logic [PtrBits-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FillBits-1:0]  fill_q, fill_d;

  assign full_o  = (fill_q == FillBits'(QueueDepth));
  assign avail_o = (fill_q != '0);
  assign cmd_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[design/bbm_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Accept boxes, mark those that fit the store, push commands to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbm_front
  import bbm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CoordBits-1:0] rect_left_i,
  input  wire logic [CoordBits-1:0] rect_top_i,
  input  wire logic [CoordBits-1:0] rect_width_i,
  input  wire logic [CoordBits-1:0] rect_height_i,
  input  wire logic                 last_box_i,
  input  wire logic                 full_i,
  output logic                      push_o,
  output bbm_cmd_t                  cmd_o
);

  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               keep;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign keep       = (cnt_q < CntBits'(MaxBoxes));

  always_comb begin
    cmd_o.box.left   = rect_left_i;
    cmd_o.box.top    = rect_top_i;
    cmd_o.box.width  = rect_width_i;
    cmd_o.box.height = rect_height_i;
    cmd_o.keep       = keep;
    cmd_o.last       = last_box_i;
    cnt_d            = cnt_q;
    if (push_o) begin
      if (last_box_i) begin
        cnt_d = '0;
      end else if (keep) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[design/bbm_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Insert boxes in left-edge order, merge greedily, emit the unions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbm_back
  import bbm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 avail_i,
  input  bbm_cmd_t                  cmd_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [CoordBits-1:0] out_left_o,
  output logic      [CoordBits-1:0] out_top_o,
  output logic      [CoordBits-1:0] out_width_o,
  output logic      [CoordBits-1:0] out_height_o,
  output logic                      out_last_o
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_INS_RD  = 8'b0000_0010,
    ST_INS_CHK = 8'b0000_0100,
    ST_SCAN    = 8'b0000_1000,
    ST_LOAD_U  = 8'b0001_0000,
    ST_J_RD    = 8'b0010_0000,
    ST_J_CHK   = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } bbm_state_e;

  localparam int PadBits = CalcBits - ExtBits;

  function automatic logic signed [CalcBits-1:0] sx(input logic [ExtBits-1:0] v);
    return $signed({{PadBits{1'b0}}, v});
  endfunction

  function automatic logic signed [CalcBits-1:0] smin(input logic signed [CalcBits-1:0] a,
                                                      input logic signed [CalcBits-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CalcBits-1:0] smax(input logic signed [CalcBits-1:0] a,
                                                      input logic signed [CalcBits-1:0] b);
    return (a > b) ? a : b;
  endfunction

  bbm_state_e            state_q, state_d;
  bbm_box_t              b_q, b_d;
  logic                  last_q, last_d;
  logic [CntBits-1:0]    count_q, count_d, k_q, k_d, i_q, i_d, j_q, j_d;
  logic [CoordBits-1:0]  ux_q, ux_d, uy_q, uy_d;
  logic [ExtBits-1:0]    uw_q, uw_d, uh_q, uh_d;
  logic                  any_left_q, any_left_d;
  logic [MaxBoxes-1:0]   absorbed_q, absorbed_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_last_q, out_last_d;
  bbm_box_t              out_q, out_d;

  logic                  we;
  logic [IdxBits-1:0]    waddr, raddr;
  bbm_box_t              wdata, rdata;
  logic [BoxBits-1:0]    rdata_raw;

  logic signed [CalcBits-1:0] ux_s, uy_s, uw_s, uh_s, jx_s, jy_s, jw_s, jh_s;
  logic signed [CalcBits-1:0] ur_s, ub_s, jr_s, jb_s, dist_s, ox_s, oy_s;
  logic signed [CalcBits-1:0] nx_s, ny_s, nw_s, nh_s;
  logic                       do_merge;

  bbm_ram #(
    .Width (BoxBits),
    .Depth (MaxBoxes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = bbm_box_t'(rdata_raw);

  always_comb begin
    ux_s   = sx({1'b0, ux_q});
    uy_s   = sx({1'b0, uy_q});
    uw_s   = sx(uw_q);
    uh_s   = sx(uh_q);
    jx_s   = sx({1'b0, rdata.left});
    jy_s   = sx({1'b0, rdata.top});
    jw_s   = sx({1'b0, rdata.width});
    jh_s   = sx({1'b0, rdata.height});
    ur_s   = ux_s + uw_s;
    ub_s   = uy_s + uh_s;
    jr_s   = jx_s + jw_s;
    jb_s   = jy_s + jh_s;
    dist_s = (ux_s + (uw_s >>> 1)) - (jx_s + (jw_s >>> 1));
    if (dist_s < 0) begin
      dist_s = -dist_s;
    end
    ox_s = (smin(ur_s, jr_s) - smax(ux_s, jx_s)) <<< 1;
    oy_s = (smin(ub_s, jb_s) - smax(uy_s, jy_s)) <<< 1;
    do_merge = (dist_s < smin(uh_s, jh_s)) ||
               (((ox_s > uw_s) || (ox_s > jw_s)) && ((oy_s > uh_s) || (oy_s > jh_s)));
    nx_s = smin(ux_s, jx_s);
    ny_s = smin(uy_s, jy_s);
    nw_s = smax(ur_s, jr_s) - nx_s;
    nh_s = smax(ub_s, jb_s) - ny_s;
  end

  always_comb begin
    state_d     = state_q;
    b_d         = b_q;
    last_d      = last_q;
    count_d     = count_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    uw_d        = uw_q;
    uh_d        = uh_q;
    any_left_d  = any_left_q;
    absorbed_d  = absorbed_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = k_q[IdxBits-1:0];
    wdata       = b_q;
    raddr       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (avail_i) begin
          pop_o  = 1'b1;
          b_d    = cmd_i.box;
          last_d = cmd_i.last;
          k_d    = count_q;
          i_d    = '0;
          if (cmd_i.keep) begin
            state_d = ST_INS_RD;
          end else if (cmd_i.last) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_INS_RD: begin
        if (k_q == '0) begin
          we      = 1'b1;
          waddr   = '0;
          count_d = count_q + 1'b1;
          state_d = last_q ? ST_SCAN : ST_IDLE;
        end else begin
          raddr   = IdxBits'(k_q - 1'b1);
          state_d = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        we = 1'b1;
        if (rdata.left > b_q.left) begin
          wdata   = rdata;
          k_d     = k_q - 1'b1;
          state_d = ST_INS_RD;
        end else begin
          count_d = count_q + 1'b1;
          state_d = last_q ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (i_q == count_q) begin
          count_d    = '0;
          absorbed_d = '0;
          state_d    = ST_IDLE;
        end else if (absorbed_q[i_q[IdxBits-1:0]]) begin
          i_d = i_q + 1'b1;
        end else begin
          raddr      = i_q[IdxBits-1:0];
          j_d        = i_q + 1'b1;
          any_left_d = 1'b0;
          state_d    = ST_LOAD_U;
        end
      end
      ST_LOAD_U: begin
        ux_d    = rdata.left;
        uy_d    = rdata.top;
        uw_d    = {1'b0, rdata.width};
        uh_d    = {1'b0, rdata.height};
        state_d = ST_J_RD;
      end
      ST_J_RD: begin
        if (j_q == count_q) begin
          state_d = ST_EMIT;
        end else if (absorbed_q[j_q[IdxBits-1:0]]) begin
          j_d = j_q + 1'b1;
        end else begin
          raddr   = j_q[IdxBits-1:0];
          state_d = ST_J_CHK;
        end
      end
      ST_J_CHK: begin
        if (do_merge) begin
          ux_d = nx_s[CoordBits-1:0];
          uy_d = ny_s[CoordBits-1:0];
          uw_d = nw_s[ExtBits-1:0];
          uh_d = nh_s[ExtBits-1:0];
          absorbed_d[j_q[IdxBits-1:0]] = 1'b1;
        end else begin
          any_left_d = 1'b1;
        end
        j_d     = j_q + 1'b1;
        state_d = ST_J_RD;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_last_d   = !any_left_q;
          out_d.left   = ux_q;
          out_d.top    = uy_q;
          out_d.width  = uw_q[ExtBits-1] ? '1 : uw_q[CoordBits-1:0];
          out_d.height = uh_q[ExtBits-1] ? '1 : uh_q[CoordBits-1:0];
          i_d          = i_q + 1'b1;
          state_d      = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      absorbed_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      absorbed_q  <= absorbed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q        <= b_d;
    last_q     <= last_d;
    k_q        <= k_d;
    i_q        <= i_d;
    j_q        <= j_d;
    ux_q       <= ux_d;
    uy_q       <= uy_d;
    uw_q       <= uw_d;
    uh_q       <= uh_d;
    any_left_q <= any_left_d;
    out_last_q <= out_last_d;
    out_q      <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_last_o   = out_last_q;
  assign out_left_o   = out_q.left;
  assign out_top_o    = out_q.top;
  assign out_width_o  = out_q.width;
  assign out_height_o = out_q.height;

endmodule

`default_nettype wire

[design/bounding_box_merge.sv]
// ----------------------------------------------------------------------------
// Bounding box merge
// Collect a set of boxes, sort by left edge, merge overlapping boxes greedily.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   input    in         in_valid_i/in_ready_o  rect_left/top/width/height, last_box
//   output   out        out_valid_o/out_ready_i out_left/top/width/height, out_last
//
// A stored box is inserted by moving each held entry with a larger left edge
// up one place in the sorted store, with one read and one write per entry.
// Merging reads each later unabsorbed box over one store read port to compare
// it with the current union, skips absorbed boxes and then emits the union,
// and it can stall at the output.
// Reset clears the control state; the box store needs no clearing.
// A two-entry queue lets input items land while the back end is busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounding_box_merge
  import bbm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CoordBits-1:0] rect_left_i,
  input  wire logic [CoordBits-1:0] rect_top_i,
  input  wire logic [CoordBits-1:0] rect_width_i,
  input  wire logic [CoordBits-1:0] rect_height_i,
  input  wire logic                 last_box_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [CoordBits-1:0] out_left_o,
  output logic      [CoordBits-1:0] out_top_o,
  output logic      [CoordBits-1:0] out_width_o,
  output logic      [CoordBits-1:0] out_height_o,
  output logic                      out_last_o
);

  bbm_cmd_t push_cmd, pop_cmd;
  logic     push, pop, full, avail;

  bbm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .last_box_i    (last_box_i),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  bbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .avail_o (avail)
  );

  bbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (avail),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_left_o   (out_left_o),
    .out_top_o    (out_top_o),
    .out_width_o  (out_width_o),
    .out_height_o (out_height_o),
    .out_last_o   (out_last_o)
  );

endmodule

`default_nettype wire

[design/bbm_checker.sv]
// ----------------------------------------------------------------------------
// Bounding box merge checker
// Port-level checks on the output channel and on set boundaries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbm_checker
  import bbm_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 last_box_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [CoordBits-1:0] out_left_o,
  input wire logic [CoordBits-1:0] out_width_o,
  input wire logic                 out_last_o
);

  logic [2:0] pending_q;
  logic       set_in, set_out;

  assign set_in  = in_valid_i && in_ready_o && last_box_i;
  assign set_out = out_valid_o && out_ready_i && out_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (set_in && !set_out) begin
      pending_q <= pending_q + 1'b1;
    end else if (set_out && !set_in) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_left_o) && $stable(out_width_o))
    else $error("output item changed while stalled");

  a_no_orphan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != '0))
    else $error("result item without a closed set");

  a_reset_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result item right after reset");

endmodule

bind bounding_box_merge bbm_checker u_bbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_box_i  (last_box_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_left_o  (out_left_o),
  .out_width_o (out_width_o),
  .out_last_o  (out_last_o)
);

`default_nettype wire
